// File: rtl/bdq_pkg.sv
// Package for the bounded double-ended queue with search.
// Holds operation codes, status codes and the controller state type.
// No dependencies.
package bdq_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_COUNT      = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SEARCH
    } t_state;

endpackage

// File: rtl/bounded_deque_with_search_top.sv
// Top level of the bounded double-ended queue with search.
// Depends on bdq_pkg; the ring store is a single-port-read synchronous memory.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+----------------------------------------
//  command  | start in, busy out             | i_op, i_item_value
//  result   | o_result_valid strobe, 1 cycle | o_status, o_popped_value,
//           |                                | o_match_count, o_occupancy
//
// Push, clear, unused codes and refused operations give their result in the cycle after
// acceptance; a successful pop passes through ST_POP for the registered memory read.
// A search passes through ST_SEARCH, where the one memory read port walks the stored
// entries one per cycle.
// Reset is synchronous and active low; it empties the queue and returns the head to 0.
// The result strobe cannot be stalled; busy is high while a pop or a search is in flight.
module bounded_deque_with_search_top
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_item_value,
    output logic               o_result_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_popped_value,
    output logic [6:0]         o_match_count,
    output logic [6:0]         o_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Adds two ring indices modulo DEPTH; both operands are below DEPTH.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // Control and queue state.
    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;

    // Search walk.
    logic [31:0]     r_key, n_key;
    logic [CW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_matches, n_matches;
    logic            r_cmp_valid, n_cmp_valid;

    // Result registers.
    logic            r_valid, n_valid;
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_popped, n_popped;
    logic [CW-1:0]   r_match_out, n_match_out;
    logic [CW-1:0]   r_occ, n_occ;

    // Memory port.
    logic [31:0]     mem [DEPTH];
    logic [31:0]     r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic            accept;
    logic            hit;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign hit    = r_cmp_valid && (r_rd_data == r_key);

    // Ring store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_cmp_valid <= n_cmp_valid;
        end
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_ptr       <= n_ptr;
        r_matches   <= n_matches;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_match_out <= n_match_out;
        r_occ       <= n_occ;
    end

    // Next state, memory controls and results.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_key       = r_key;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_matches   = r_matches;
        n_cmp_valid = 1'b0;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_popped    = r_popped;
        n_match_out = r_match_out;
        n_occ       = r_occ;
        mem_we      = 1'b0;
        mem_waddr   = ring_add(r_head, r_count[AW-1:0]);
        mem_wdata   = $unsigned(i_item_value);
        mem_raddr   = r_head;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Most operations finish here; preset an OK result.
                    n_valid     = 1'b1;
                    n_status    = STATUS_OK;
                    n_popped    = '0;
                    n_match_out = '0;
                    n_occ       = r_count;
                    case (i_op)
                        OP_PUSH_BACK: begin
                            if (r_count == FULL_CNT) begin
                                n_status = STATUS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = ring_add(r_head, r_count[AW-1:0]);
                                n_count   = r_count + 1'b1;
                                n_occ     = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (r_count == FULL_CNT) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_head    = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = n_head;
                                n_count   = r_count + 1'b1;
                                n_occ     = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                // The value arrives from the memory next cycle.
                                n_valid = 1'b0;
                                n_count = r_count - 1'b1;
                                n_state = ST_POP;
                                if (i_op == OP_POP_FRONT) begin
                                    mem_raddr = r_head;
                                    n_head    = ring_add(r_head, AW'(1));
                                end else begin
                                    mem_raddr = ring_add(r_head, AW'(r_count - 1'b1));
                                end
                            end
                        end
                        OP_COUNT: begin
                            if (r_count == '0) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_valid   = 1'b0;
                                n_key     = $unsigned(i_item_value);
                                n_idx     = '0;
                                n_ptr     = r_head;
                                n_matches = '0;
                                n_state   = ST_SEARCH;
                            end
                        end
                        OP_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                            n_occ   = '0;
                        end
                        default: begin
                            // Unused codes leave the queue as it is.
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_valid     = 1'b1;
                n_status    = STATUS_OK;
                n_popped    = r_rd_data;
                n_match_out = '0;
                n_occ       = r_count;
                n_state     = ST_IDLE;
            end
            ST_SEARCH: begin
                // Compare the entry read last cycle while the next one is fetched.
                n_matches = r_matches + CW'(hit);
                if (r_idx != r_count) begin
                    mem_raddr   = r_ptr;
                    n_ptr       = ring_add(r_ptr, AW'(1));
                    n_idx       = r_idx + 1'b1;
                    n_cmp_valid = 1'b1;
                end else begin
                    n_valid     = 1'b1;
                    n_status    = STATUS_OK;
                    n_popped    = '0;
                    n_match_out = r_matches + CW'(hit);
                    n_occ       = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result ports.
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = $signed(r_popped);
    assign o_match_count  = 7'(r_match_out);
    assign o_occupancy    = 7'(r_occ);

endmodule

// File: rtl/bdq_checker.sv
// Port-level checks for the bounded double-ended queue with search.
// Depends on bdq_pkg; bound to bounded_deque_with_search_top below.
module bdq_checker
    import bdq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_valid,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_popped_value,
    input logic [6:0]         o_match_count
);

    // A result is only presented once the block has finished with the transaction.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted transaction neither finished nor in progress");

    // Only the three defined status codes are reported.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status == STATUS_OK || o_status == STATUS_EMPTY ||
                            o_status == STATUS_FULL))
        else $error("undefined status code");

    // A refused operation returns no popped value and no match count.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STATUS_OK) |->
            (o_popped_value == 32'sd0 && o_match_count == 7'd0))
        else $error("refused operation returned data");

endmodule

bind bounded_deque_with_search_top bdq_checker u_bdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_popped_value (o_popped_value),
    .o_match_count  (o_match_count)
);
